// ===== src/pms_pkg.sv =====
// Shared types and constants for the PWM melody sequencer.
package pms_pkg;

    localparam int PERIOD_W   = 16;
    localparam int DURATION_W = 13;
    localparam int POS_W      = 9;
    localparam int VOLUME_W   = 7;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 16;
    localparam int PROD_W     = 22;   // (period/2) * volume
    localparam int RECIP_W    = 23;

    // Request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_PLAY = 2'd2;
    localparam logic [1:0] REQ_STOP = 2'd3;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_LOOP   = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_VOLUME = 2'd2;

    localparam int PADDR_W = 4;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd1;

    // x / 100 == (x * DUTY_RECIP) >> DUTY_SHIFT for every x below 2**22
    localparam logic [RECIP_W-1:0] DUTY_RECIP = 23'd5368710;
    localparam int                 DUTY_SHIFT = 29;
    localparam logic [PROD_W-1:0]  DUTY_ONE   = 22'd100;

    typedef struct packed {
        logic [PERIOD_W-1:0]   period;
        logic [DURATION_W-1:0] duration;
    } t_note;

endpackage

// ===== src/pms_if.sv =====
// Handshake interfaces for the request and result channels.
interface pms_req_if
    import pms_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic                  tone_tick;
    logic                  duration_tick;
    logic [INDEX_W-1:0]    entry_index;
    logic [PERIOD_W-1:0]   entry_period;
    logic [DURATION_W-1:0] entry_duration;

    modport source (
        output valid, req_type, tone_tick, duration_tick,
               entry_index, entry_period, entry_duration,
        input  ready
    );
    modport sink (
        input  valid, req_type, tone_tick, duration_tick,
               entry_index, entry_period, entry_duration,
        output ready
    );
endinterface

interface pms_res_if
    import pms_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             tone_level;
    logic             playing;
    logic [POS_W-1:0] position;

    modport source (
        output valid, tone_level, playing, position,
        input  ready
    );
    modport sink (
        input  valid, tone_level, playing, position,
        output ready
    );
endinterface

// ===== src/pms_note_table.sv =====
// Note table memory: one write port, one registered read port with write bypass.
module pms_note_table
    import pms_pkg::*;
#(
    parameter int SLOTS = 256,
    localparam int AW = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_note         i_wr_note,
    input  logic [AW-1:0] i_rd_addr,
    output t_note         o_rd_note
);

    t_note r_mem [SLOTS];
    t_note r_rd_data;
    t_note r_wr_note;
    logic  r_bypass;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_note;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_wr_note <= i_wr_note;
        r_bypass  <= i_wr_en && (i_wr_addr == i_rd_addr);
    end

    // Same-edge write to the address being read: return the new note
    assign o_rd_note = r_bypass ? r_wr_note : r_rd_data;

endmodule

// ===== src/pwm_melody_sequencer_unit.sv =====
// Top level of the PWM melody sequencer: timers, song control and result register.
//
// Usage:
//   i_req carries request beats: tick (tone and duration steps), load of one
//   note table slot, play (rewind, start after two duration ticks) and stop.
//   o_res returns exactly one beat per request: the tone output level, the
//   playing flag and the index of the next note, all taken after the update.
//   The APB port holds loop_enable (0x0), song_length (0x4) and volume (0x8);
//   write it only while no request is in flight.
// Throughput and timing:
//   One request per cycle unless o_res stalls. The result of a request sits in the output
//   register in the cycle after its acceptance. The note table is a one-port-read
//   memory that always reads the slot of the next note, so the note taken on a
//   duration wrap is already at hand; the duty product is registered and its
//   divide by one hundred (a reciprocal multiply) is done in the next cycle.
// Reset:
//   i_rst_n (synchronous, active low) stops both timers, rewinds the song and
//   returns the registers to loop off, length zero, volume one. The note
//   table is not cleared; a slot must be loaded before it is played.
// Stall:
//   While o_res is stalled with a beat waiting, i_req.ready drops; a new
//   request is taken in the same cycle the waiting beat leaves.
module pwm_melody_sequencer_unit
    import pms_pkg::*;
#(
    parameter int NOTE_SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pms_req_if.sink            i_req,
    pms_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SLOT_W = $clog2(NOTE_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NOTE_SLOTS - 1);

    // Configuration registers
    logic                r_loop_en;
    logic [POS_W-1:0]    r_song_len;
    logic [VOLUME_W-1:0] r_volume;

    // Timer and song state
    logic [COUNT_W-1:0] r_tone_count, n_tone_count;
    logic [COUNT_W-1:0] r_tone_top,   n_tone_top;
    logic [PROD_W-1:0]  r_duty_prod,  n_duty_prod;
    logic               r_tone_run,   n_tone_run;
    logic [COUNT_W-1:0] r_time_count, n_time_count;
    logic [COUNT_W-1:0] r_time_top,   n_time_top;
    logic               r_time_run,   n_time_run;
    logic [POS_W-1:0]   r_pos,        n_pos;
    logic [SLOT_W-1:0]  r_slot,       n_slot;

    // Result register
    logic             r_out_valid;
    logic             r_out_level;
    logic             r_out_playing;
    logic [POS_W-1:0] r_out_pos;

    logic               accept;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    t_note              wr_note;
    t_note              note;
    logic [PROD_W-1:0]  prod_new;
    logic [COUNT_W-1:0] dur16;
    logic [COUNT_W-1:0] dur_top;
    logic [PROD_W+RECIP_W-1:0] duty_mul;
    logic [COUNT_W-1:0] duty_cur;
    logic               took_tone;
    logic               n_level;
    logic [SLOT_W+INDEX_W-1:0] idx_ext;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_en  <= 1'b0;
            r_song_len <= '0;
            r_volume   <= VOLUME_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LOOP:   r_loop_en  <= pwdata[0];
                REG_LENGTH: r_song_len <= pwdata[POS_W-1:0];
                REG_VOLUME: r_volume   <= pwdata[VOLUME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOOP:   prdata = {31'b0, r_loop_en};
            REG_LENGTH: prdata = {{(32-POS_W){1'b0}}, r_song_len};
            REG_VOLUME: prdata = {{(32-VOLUME_W){1'b0}}, r_volume};
            default:    prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Note table: always reads the slot that the next note comes from
    //------------------------------------------------------------------
    assign idx_ext = (SLOT_W + INDEX_W)'(i_req.entry_index);
    assign wr_addr = idx_ext[SLOT_W-1:0];
    assign wr_note = '{period: i_req.entry_period, duration: i_req.entry_duration};
    assign wr_en   = accept && (i_req.req_type == REQ_LOAD)
                     && (32'(i_req.entry_index) < NOTE_SLOTS);

    pms_note_table #(
        .SLOTS (NOTE_SLOTS)
    ) u_note_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_note (wr_note),
        .i_rd_addr (n_slot),
        .o_rd_note (note)
    );

    //------------------------------------------------------------------
    // Note arithmetic
    //------------------------------------------------------------------
    // Product for the duty compare; registered, then divided by one hundred
    assign prod_new = PROD_W'(note.period[PERIOD_W-1:1]) * PROD_W'(r_volume);
    assign dur16    = COUNT_W'(note.duration);
    assign dur_top  = (dur16 << 3) + (dur16 << 1);

    assign duty_mul = (PROD_W + RECIP_W)'(r_duty_prod) * (PROD_W + RECIP_W)'(DUTY_RECIP);
    assign duty_cur = COUNT_W'(duty_mul >> DUTY_SHIFT);

    //------------------------------------------------------------------
    // Request handling
    //------------------------------------------------------------------
    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_tone_count = r_tone_count;
        n_tone_top   = r_tone_top;
        n_duty_prod  = r_duty_prod;
        n_tone_run   = r_tone_run;
        n_time_count = r_time_count;
        n_time_top   = r_time_top;
        n_time_run   = r_time_run;
        n_pos        = r_pos;
        n_slot       = r_slot;
        took_tone    = 1'b0;

        if (accept) begin
            case (i_req.req_type)
                REQ_TICK: begin
                    // Tone counter steps first, then the duration timer
                    if (i_req.tone_tick && r_tone_run) begin
                        n_tone_count = (r_tone_count >= r_tone_top) ? '0 : r_tone_count + 1'b1;
                    end
                    if (i_req.duration_tick && r_time_run) begin
                        if (r_time_count >= r_time_top) begin
                            // Duration wrap: take the next note
                            n_time_count = '0;
                            n_tone_run   = 1'b0;
                            n_time_run   = 1'b0;
                            if (r_pos < r_song_len) begin
                                if (note.period != '0) begin
                                    n_tone_top   = note.period;
                                    n_duty_prod  = prod_new;
                                    n_tone_count = '0;
                                    n_tone_run   = 1'b1;
                                    took_tone    = 1'b1;
                                end
                                n_time_top = dur_top;
                                n_time_run = 1'b1;
                                n_pos      = r_pos + 1'b1;
                                n_slot     = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                            end else if (r_loop_en) begin
                                n_pos      = '0;
                                n_slot     = '0;
                                n_time_top = COUNT_W'(1);
                                n_time_run = 1'b1;
                            end
                        end else begin
                            n_time_count = r_time_count + 1'b1;
                        end
                    end
                end
                REQ_PLAY: begin
                    n_tone_run   = 1'b0;
                    n_pos        = '0;
                    n_slot       = '0;
                    n_time_count = '0;
                    n_time_top   = COUNT_W'(1);
                    n_time_run   = 1'b1;
                end
                REQ_STOP: begin
                    n_tone_run = 1'b0;
                    n_time_run = 1'b0;
                end
                default: ;  // load: table write only
            endcase
        end

        // A fresh note starts its tone count at zero, so it is high iff duty is nonzero
        if (took_tone) begin
            n_level = (n_duty_prod >= DUTY_ONE);
        end else begin
            n_level = n_tone_run && (n_tone_count < duty_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_count <= '0;
            r_tone_top   <= '0;
            r_duty_prod  <= '0;
            r_tone_run   <= 1'b0;
            r_time_count <= '0;
            r_time_top   <= '0;
            r_time_run   <= 1'b0;
            r_pos        <= '0;
            r_slot       <= '0;
        end else begin
            r_tone_count <= n_tone_count;
            r_tone_top   <= n_tone_top;
            r_duty_prod  <= n_duty_prod;
            r_tone_run   <= n_tone_run;
            r_time_count <= n_time_count;
            r_time_top   <= n_time_top;
            r_time_run   <= n_time_run;
            r_pos        <= n_pos;
            r_slot       <= n_slot;
        end
    end

    //------------------------------------------------------------------
    // Result register: hold the beat until the sink takes it
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_level   <= n_level;
            r_out_playing <= n_time_run;
            r_out_pos     <= n_pos;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.tone_level = r_out_level;
    assign o_res.playing    = r_out_playing;
    assign o_res.position   = r_out_pos;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_tone_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone_run |-> r_time_run)
        else $error("tone running without duration timer");

    a_tone_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone_run |-> (r_tone_count <= r_tone_top))
        else $error("tone count beyond its top");

    a_slot_tracks_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pos) < NOTE_SLOTS) |-> (32'(r_slot) == 32'(r_pos)))
        else $error("table slot out of step with song position");

    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result beat");

endmodule
